FILE: sv/sm83_pkg.sv
// Shared types and constants of the SM83 eight-bit ALU.
`timescale 1ns / 1ps

package sm83_pkg;

  // Operation codes carried on the input tuser.
  typedef enum logic [4:0] {
    ACT_ADD  = 5'd0,
    ACT_ADC  = 5'd1,
    ACT_SUB  = 5'd2,
    ACT_SBC  = 5'd3,
    ACT_CP   = 5'd4,
    ACT_AND  = 5'd5,
    ACT_OR   = 5'd6,
    ACT_XOR  = 5'd7,
    ACT_INC  = 5'd8,
    ACT_DEC  = 5'd9,
    ACT_DAA  = 5'd10,
    ACT_CPL  = 5'd11,
    ACT_SCF  = 5'd12,
    ACT_CCF  = 5'd13,
    ACT_RLCA = 5'd14,
    ACT_RLA  = 5'd15,
    ACT_RRCA = 5'd16,
    ACT_RRA  = 5'd17,
    ACT_RLC  = 5'd18,
    ACT_RRC  = 5'd19,
    ACT_RL   = 5'd20,
    ACT_RR   = 5'd21,
    ACT_SLA  = 5'd22,
    ACT_SRA  = 5'd23,
    ACT_SRL  = 5'd24,
    ACT_SWAP = 5'd25,
    ACT_BIT  = 5'd26,
    ACT_RES  = 5'd27,
    ACT_SET  = 5'd28
  } action_e;

  // Decimal adjust constants.
  localparam logic [7:0] DaaLoAdj   = 8'h06;
  localparam logic [7:0] DaaHiAdj   = 8'h60;
  localparam logic [7:0] DaaHiLimit = 8'h99;
  localparam logic [3:0] DaaLoLimit = 4'h9;

  // Processor flags.
  typedef struct packed {
    logic z;
    logic n;
    logic h;
    logic c;
  } flags_t;

  // One operation as held in the input register.
  typedef struct packed {
    action_e     action;
    logic [7:0]  operand_a;
    logic [7:0]  operand_b;
    logic [2:0]  bit_index;
    flags_t      flags;
  } alu_req_t;

  // One finished result.
  typedef struct packed {
    logic [7:0] result;
    logic       write_back;
    flags_t     flags;
  } alu_rsp_t;

endpackage

FILE: sv/sm83_alu_calc.sv
// Combinational datapath of the SM83 ALU: one operation to one result.
`timescale 1ns / 1ps

module sm83_alu_calc
  import sm83_pkg::*;
(
  input  alu_req_t req_i,
  output alu_rsp_t rsp_o
);

  logic [7:0] a;
  logic [7:0] b;
  logic       ci;
  logic       carry_sel;
  logic [8:0] add_sum;
  logic [4:0] add_half;
  logic [8:0] sub_diff;
  logic [4:0] sub_half;
  logic       daa_lo;
  logic       daa_hi;
  logic [7:0] daa_adj;
  logic [7:0] bit_mask;

  assign a  = req_i.operand_a;
  assign b  = req_i.operand_b;
  assign ci = req_i.flags.c;

  // The adder and subtractor take carry in only in the with-carry forms.
  assign carry_sel = ((req_i.action == ACT_ADC) || (req_i.action == ACT_SBC)) ? ci : 1'b0;

  // Shared adder and subtractor with their half-carry nibbles.
  assign add_sum  = {1'b0, a} + {1'b0, b} + {8'd0, carry_sel};
  assign add_half = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, carry_sel};
  assign sub_diff = {1'b0, a} - {1'b0, b} - {8'd0, carry_sel};
  assign sub_half = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, carry_sel};

  // Decimal adjust selects the low and high corrections from the incoming flags.
  assign daa_lo  = req_i.flags.h || (!req_i.flags.n && (a[3:0] > DaaLoLimit));
  assign daa_hi  = ci || (!req_i.flags.n && (a > DaaHiLimit));
  assign daa_adj = (daa_lo ? DaaLoAdj : 8'h00) | (daa_hi ? DaaHiAdj : 8'h00);

  assign bit_mask = 8'h01 << req_i.bit_index;

  // Operation select.
  always_comb begin
    rsp_o.result     = a;
    rsp_o.write_back = 1'b1;
    rsp_o.flags      = req_i.flags;
    case (req_i.action)
      ACT_ADD, ACT_ADC: begin
        rsp_o.result = add_sum[7:0];
        rsp_o.flags  = '{z: (add_sum[7:0] == 8'd0), n: 1'b0, h: add_half[4], c: add_sum[8]};
      end
      ACT_SUB, ACT_SBC, ACT_CP: begin
        rsp_o.result     = sub_diff[7:0];
        rsp_o.write_back = (req_i.action != ACT_CP);
        rsp_o.flags = '{z: (sub_diff[7:0] == 8'd0), n: 1'b1, h: sub_half[4], c: sub_diff[8]};
      end
      ACT_AND: begin
        rsp_o.result = a & b;
        rsp_o.flags  = '{z: ((a & b) == 8'd0), n: 1'b0, h: 1'b1, c: 1'b0};
      end
      ACT_OR: begin
        rsp_o.result = a | b;
        rsp_o.flags  = '{z: ((a | b) == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
      end
      ACT_XOR: begin
        rsp_o.result = a ^ b;
        rsp_o.flags  = '{z: ((a ^ b) == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
      end
      ACT_INC: begin
        rsp_o.result = a + 8'd1;
        rsp_o.flags  = '{z: (a == 8'hFF), n: 1'b0, h: (a[3:0] == 4'hF), c: ci};
      end
      ACT_DEC: begin
        rsp_o.result = a - 8'd1;
        rsp_o.flags  = '{z: (a == 8'h01), n: 1'b1, h: (a[3:0] == 4'h0), c: ci};
      end
      ACT_DAA: begin
        rsp_o.result = req_i.flags.n ? (a - daa_adj) : (a + daa_adj);
        rsp_o.flags  = '{z: ((req_i.flags.n ? (a - daa_adj) : (a + daa_adj)) == 8'd0),
                         n: req_i.flags.n, h: 1'b0, c: daa_hi};
      end
      ACT_CPL: begin
        rsp_o.result = ~a;
        rsp_o.flags  = '{z: req_i.flags.z, n: 1'b1, h: 1'b1, c: ci};
      end
      ACT_SCF: begin
        rsp_o.flags = '{z: req_i.flags.z, n: 1'b0, h: 1'b0, c: 1'b1};
      end
      ACT_CCF: begin
        rsp_o.flags = '{z: req_i.flags.z, n: 1'b0, h: 1'b0, c: ~ci};
      end
      // Accumulator rotates always clear Z.
      ACT_RLCA: begin
        rsp_o.result = {a[6:0], a[7]};
        rsp_o.flags  = '{z: 1'b0, n: 1'b0, h: 1'b0, c: a[7]};
      end
      ACT_RLA: begin
        rsp_o.result = {a[6:0], ci};
        rsp_o.flags  = '{z: 1'b0, n: 1'b0, h: 1'b0, c: a[7]};
      end
      ACT_RRCA: begin
        rsp_o.result = {a[0], a[7:1]};
        rsp_o.flags  = '{z: 1'b0, n: 1'b0, h: 1'b0, c: a[0]};
      end
      ACT_RRA: begin
        rsp_o.result = {ci, a[7:1]};
        rsp_o.flags  = '{z: 1'b0, n: 1'b0, h: 1'b0, c: a[0]};
      end
      // Prefixed rotates and shifts set Z from the result.
      ACT_RLC: begin
        rsp_o.result = {a[6:0], a[7]};
        rsp_o.flags  = '{z: (a == 8'd0), n: 1'b0, h: 1'b0, c: a[7]};
      end
      ACT_RRC: begin
        rsp_o.result = {a[0], a[7:1]};
        rsp_o.flags  = '{z: (a == 8'd0), n: 1'b0, h: 1'b0, c: a[0]};
      end
      ACT_RL: begin
        rsp_o.result = {a[6:0], ci};
        rsp_o.flags  = '{z: ({a[6:0], ci} == 8'd0), n: 1'b0, h: 1'b0, c: a[7]};
      end
      ACT_RR: begin
        rsp_o.result = {ci, a[7:1]};
        rsp_o.flags  = '{z: ({ci, a[7:1]} == 8'd0), n: 1'b0, h: 1'b0, c: a[0]};
      end
      ACT_SLA: begin
        rsp_o.result = {a[6:0], 1'b0};
        rsp_o.flags  = '{z: (a[6:0] == 7'd0), n: 1'b0, h: 1'b0, c: a[7]};
      end
      ACT_SRA: begin
        rsp_o.result = {a[7], a[7:1]};
        rsp_o.flags  = '{z: (a[7:1] == 7'd0), n: 1'b0, h: 1'b0, c: a[0]};
      end
      ACT_SRL: begin
        rsp_o.result = {1'b0, a[7:1]};
        rsp_o.flags  = '{z: (a[7:1] == 7'd0), n: 1'b0, h: 1'b0, c: a[0]};
      end
      ACT_SWAP: begin
        rsp_o.result = {a[3:0], a[7:4]};
        rsp_o.flags  = '{z: (a == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
      end
      ACT_BIT: begin
        rsp_o.write_back = 1'b0;
        rsp_o.flags = '{z: ((a & bit_mask) == 8'd0), n: 1'b0, h: 1'b1, c: ci};
      end
      ACT_RES: begin
        rsp_o.result = a & ~bit_mask;
      end
      ACT_SET: begin
        rsp_o.result = a | bit_mask;
      end
      // Unassigned codes pass operand A and the flags through without write back.
      default: begin
        rsp_o.write_back = 1'b0;
      end
    endcase
  end

endmodule

FILE: sv/sm83_eight_bit_alu_core.sv
// Top level of the SM83 eight-bit ALU: input register, datapath, result register.
//
// Usage: operations arrive on the slave stream. The operation code travels on
// s_axis_tuser_i; tdata carries operand A, operand B, the bit index and the
// incoming Z, N, H and C flags. Results leave on the master stream: tdata holds
// the result byte and the new flags, tuser is the write-back flag (low for
// compare, bit test and unassigned codes).
// Path: an accepted item is registered in the input register, computed by a
// single combinational pass and registered again in the result register, which
// drives the master side; a stalled receiver holds it there.
// Throughput: one item per cycle while the receiver takes every result; the
// input register and the result register form a two-stage pipeline that
// advances whenever the result register is empty or being taken.
// Stall: while the receiver holds m_axis_tready_i low, the result stays put,
// the input register fills and then s_axis_tready_o drops; nothing is lost.
// Reset: rst_ni clears both stage valid bits; no results are pending after
// reset and s_axis_tready_o is high as soon as reset is released.
`timescale 1ns / 1ps

module sm83_eight_bit_alu_core
  import sm83_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // Slave stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [7:0] operand_a, [15:8] operand_b, [18:16] bit_index, [19] zero_in,
  // [20] subtract_in, [21] half_carry_in, [22] carry_in, [23] zero fill
  input  logic [23:0] s_axis_tdata_i,
  // [4:0] action
  input  logic [4:0]  s_axis_tuser_i,
  // Master stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [7:0] result, [8] zero_out, [9] subtract_out, [10] half_carry_out,
  // [11] carry_out, [15:12] zero fill
  output logic [15:0] m_axis_tdata_o,
  // [0] write_back
  output logic        m_axis_tuser_o
);

  logic     in_valid_q;
  logic     out_valid_q;
  alu_req_t req_q;
  alu_req_t req_d;
  alu_rsp_t rsp_d;
  alu_rsp_t rsp_q;
  logic     out_load;
  logic     in_load;

  // Pipeline advance: the result register takes a new item when empty or drained.
  assign out_load        = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || out_load;
  assign in_load         = s_axis_tvalid_i && s_axis_tready_o;

  // Unpack the incoming item.
  always_comb begin
    req_d.action    = action_e'(s_axis_tuser_i);
    req_d.operand_a = s_axis_tdata_i[7:0];
    req_d.operand_b = s_axis_tdata_i[15:8];
    req_d.bit_index = s_axis_tdata_i[18:16];
    req_d.flags     = '{z: s_axis_tdata_i[19], n: s_axis_tdata_i[20],
                        h: s_axis_tdata_i[21], c: s_axis_tdata_i[22]};
  end

  // Stage valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready_o) begin
        in_valid_q <= s_axis_tvalid_i;
      end
      if (!out_valid_q || m_axis_tready_i) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_load) begin
      req_q <= req_d;
    end
    if (out_load) begin
      rsp_q <= rsp_d;
    end
  end

  sm83_alu_calc u_calc (
    .req_i (req_q),
    .rsp_o (rsp_d)
  );

  // Pack the result.
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {4'd0, rsp_q.flags.c, rsp_q.flags.h, rsp_q.flags.n,
                            rsp_q.flags.z, rsp_q.result};
  assign m_axis_tuser_o  = rsp_q.write_back;

  // An accepted item always lands in the input register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> in_valid_q)
    else $error("accepted item did not reach the input register");

  // A stalled result keeps a full input register full.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && out_valid_q && !m_axis_tready_i) |=> in_valid_q)
    else $error("input register dropped an item during a stall");

  // An item leaving the input register becomes a visible result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> out_valid_q)
    else $error("result register lost an item");

endmodule
